// File: hdl/sha1md_pkg.sv
// ============================================================================
// sha1md_pkg
// Shared types, constants and helper function of the SHA-1 digest block.
// ============================================================================
`default_nettype none

package sha1md_pkg;

    // initial chain value
    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hefcdab89;
    localparam logic [31:0] IV2 = 32'h98badcfe;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hc3d2e1f0;

    // round constants
    localparam logic [31:0] K0 = 32'h5a827999;
    localparam logic [31:0] K1 = 32'h6ed9eba1;
    localparam logic [31:0] K2 = 32'h8f1bbcdc;
    localparam logic [31:0] K3 = 32'hca62c1d6;

    // padding marker byte placed in the top lane of a word
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam logic [31:0] PAD_WORD = {PAD_BYTE, 24'h000000};

    localparam int unsigned ROUNDS     = 80;
    localparam int unsigned ROUND_W    = 7;
    localparam int unsigned BLOCK_WORDS = 16;
    localparam int unsigned COUNT_W    = 4;

    // the five working or chain words
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
    } sha1md_vars_t;

    localparam sha1md_vars_t CHAIN_IV = '{a: IV0, b: IV1, c: IV2, d: IV3, e: IV4};

    // input request payload
    typedef struct packed {
        logic [31:0] message_word;
        logic [2:0]  valid_bytes;
        logic        final_word;
    } sha1md_in_t;

    // output request payload
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  digest_index;
        logic        digest_done;
    } sha1md_out_t;

    // commands from the padding sequencer to the compression core
    typedef struct packed {
        logic push;
        logic init;
    } sha1md_ctrl_t;

    // core status seen by the padding sequencer
    typedef struct packed {
        logic               ready;
        logic [COUNT_W-1:0] word_count;
    } sha1md_status_t;

    // round constant by round number
    function automatic logic [31:0] round_k(input logic [ROUND_W-1:0] round);
        logic [31:0] k;
        if (round < ROUND_W'(20))
            k = K0;
        else if (round < ROUND_W'(40))
            k = K1;
        else if (round < ROUND_W'(60))
            k = K2;
        else
            k = K3;
        return k;
    endfunction

endpackage

`default_nettype wire

// File: hdl/sha1md_round.sv
// ============================================================================
// sha1md_round
// One SHA-1 compression round: boolean function, five-way add and rotate.
// ============================================================================
`default_nettype none

module sha1md_round (
    input  wire logic [sha1md_pkg::ROUND_W-1:0] round,
    input  wire sha1md_pkg::sha1md_vars_t       vars,
    input  wire logic [31:0]                    w,
    output sha1md_pkg::sha1md_vars_t            vars_next
);

    logic [31:0] f;
    logic [31:0] temp;

    // round function by round range
    always_comb
    begin
        if (round < sha1md_pkg::ROUND_W'(20))
            f = (vars.b & vars.c) | (~vars.b & vars.d);
        else if (round < sha1md_pkg::ROUND_W'(40))
            f = vars.b ^ vars.c ^ vars.d;
        else if (round < sha1md_pkg::ROUND_W'(60))
            f = (vars.b & vars.c) | (vars.b & vars.d) | (vars.c & vars.d);
        else
            f = vars.b ^ vars.c ^ vars.d;
    end

    // rotl5(a) + f + e + w + k
    assign temp = {vars.a[26:0], vars.a[31:27]} + f + vars.e + w
                  + sha1md_pkg::round_k(round);

    // shift the working words down by one
    assign vars_next.a = temp;
    assign vars_next.b = vars.a;
    assign vars_next.c = {vars.b[1:0], vars.b[31:2]};
    assign vars_next.d = vars.c;
    assign vars_next.e = vars.d;

endmodule

`default_nettype wire

// File: hdl/sha1md_core.sv
// ============================================================================
// sha1md_core
// Block buffer, message schedule and 80-round iterative compression.
// ============================================================================
`default_nettype none

module sha1md_core (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire sha1md_pkg::sha1md_ctrl_t  ctrl,
    input  wire logic [31:0]               push_word,
    output sha1md_pkg::sha1md_status_t     status,
    output sha1md_pkg::sha1md_vars_t       chain
);

    localparam logic [1:0] ST_LOAD   = 2'd0;
    localparam logic [1:0] ST_ROUND  = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    localparam logic [sha1md_pkg::ROUND_W-1:0] LAST_ROUND =
        sha1md_pkg::ROUND_W'(sha1md_pkg::ROUNDS - 1);
    localparam logic [sha1md_pkg::COUNT_W-1:0] LAST_WORD =
        sha1md_pkg::COUNT_W'(sha1md_pkg::BLOCK_WORDS - 1);

    logic [1:0]                         state_reg;
    logic [1:0]                         state_next;
    logic [sha1md_pkg::ROUND_W-1:0]     round_reg;
    logic [sha1md_pkg::ROUND_W-1:0]     round_next;
    logic [sha1md_pkg::COUNT_W-1:0]     count_reg;
    logic [sha1md_pkg::COUNT_W-1:0]     count_next;
    sha1md_pkg::sha1md_vars_t           chain_reg;
    sha1md_pkg::sha1md_vars_t           chain_next;
    sha1md_pkg::sha1md_vars_t           work_reg;
    sha1md_pkg::sha1md_vars_t           work_next;
    sha1md_pkg::sha1md_vars_t           round_vars;
    logic [31:0]                        window_reg [sha1md_pkg::BLOCK_WORDS];
    logic [31:0]                        sched_mix;
    logic [31:0]                        sched_new;
    logic                               load_push;

    assign load_push = (state_reg == ST_LOAD) && ctrl.push;

    // next schedule word from the fixed taps of the window
    assign sched_mix = window_reg[13] ^ window_reg[8] ^ window_reg[2] ^ window_reg[0];
    assign sched_new = {sched_mix[30:0], sched_mix[31]};

    // shared round unit, oldest window word is the round's w
    sha1md_round u_round (
        .round     (round_reg),
        .vars      (work_reg),
        .w         (window_reg[0]),
        .vars_next (round_vars)
    );

    // sequencer: load sixteen words, run eighty rounds, fold into chain
    always_comb
    begin
        state_next = state_reg;
        round_next = round_reg;
        count_next = count_reg;
        chain_next = chain_reg;
        work_next  = work_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (ctrl.init)
                    chain_next = sha1md_pkg::CHAIN_IV;
                if (ctrl.push)
                begin
                    count_next = count_reg + sha1md_pkg::COUNT_W'(1);
                    if (count_reg == LAST_WORD)
                    begin
                        work_next  = chain_reg;
                        round_next = '0;
                        state_next = ST_ROUND;
                    end
                end
            end
            ST_ROUND:
            begin
                work_next  = round_vars;
                round_next = round_reg + sha1md_pkg::ROUND_W'(1);
                if (round_reg == LAST_ROUND)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                chain_next.a = chain_reg.a + work_reg.a;
                chain_next.b = chain_reg.b + work_reg.b;
                chain_next.c = chain_reg.c + work_reg.c;
                chain_next.d = chain_reg.d + work_reg.d;
                chain_next.e = chain_reg.e + work_reg.e;
                state_next   = ST_LOAD;
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            round_reg <= '0;
            count_reg <= '0;
            chain_reg <= sha1md_pkg::CHAIN_IV;
            work_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            round_reg <= round_next;
            count_reg <= count_next;
            chain_reg <= chain_next;
            work_reg  <= work_next;
        end
    end

    // schedule window: shift line fed by pushes or by the schedule
    always_ff @(posedge clk)
    begin
        if (load_push || (state_reg == ST_ROUND))
        begin
            for (int i = 0; i < sha1md_pkg::BLOCK_WORDS - 1; i++)
            begin
                window_reg[i] <= window_reg[i+1];
            end
            window_reg[sha1md_pkg::BLOCK_WORDS-1] <= load_push ? push_word : sched_new;
        end
    end

    assign status.ready      = (state_reg == ST_LOAD);
    assign status.word_count = count_reg;
    assign chain             = chain_reg;

endmodule

`default_nettype wire

// File: hdl/sha1_message_digest.sv
// ============================================================================
// sha1_message_digest
// SHA-1 hash over a stream of big-endian 32-bit message words.
// ============================================================================
// Each request carries one message word, first byte in bits 31..24; the
// word flagged final_word gives its count of valid bytes (0 to 4, larger
// counts act as 4) and starts padding, after which the five digest words
// H0..H4 come out as five output requests, then the block is ready for a
// new message. Each word goes into the core's block buffer; the sixteenth
// word of a block starts a compression (80 rounds through one shared round
// unit plus one chain update), during which no new word is taken. On the
// final word the sequencer pushes the pad and length words one per cycle
// while the core is ready, with one or two compressions, before the digest
// is offered one word per cycle while digest_ready is high.
// ============================================================================
`default_nettype none

module sha1_message_digest (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    message_valid,
    output logic                         message_ready,
    input  wire sha1md_pkg::sha1md_in_t  message,
    output logic                         digest_valid,
    input  wire logic                    digest_ready,
    output sha1md_pkg::sha1md_out_t      digest
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_PAD    = 3'd1;
    localparam logic [2:0] ST_ZERO   = 3'd2;
    localparam logic [2:0] ST_LEN_LO = 3'd3;
    localparam logic [2:0] ST_WAIT   = 3'd4;
    localparam logic [2:0] ST_OUT    = 3'd5;

    localparam logic [2:0] LAST_INDEX = 3'd4;
    localparam logic [sha1md_pkg::COUNT_W-1:0] LEN_HI_SLOT =
        sha1md_pkg::COUNT_W'(sha1md_pkg::BLOCK_WORDS - 2);

    logic [2:0]                  state_reg;
    logic [2:0]                  state_next;
    logic [2:0]                  index_reg;
    logic [2:0]                  index_next;
    logic [63:0]                 bitlen_reg;
    logic [63:0]                 bitlen_next;
    sha1md_pkg::sha1md_ctrl_t    core_ctrl;
    sha1md_pkg::sha1md_status_t  core_status;
    sha1md_pkg::sha1md_vars_t    chain;
    logic [31:0]                 push_word;
    logic [2:0]                  nbytes;
    logic [31:0]                 keep_mask;
    logic [31:0]                 pad_bits;
    logic [31:0]                 out_word;
    logic                        in_take;
    logic                        out_take;

    sha1md_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (core_ctrl),
        .push_word (push_word),
        .status    (core_status),
        .chain     (chain)
    );

    assign message_ready = (state_reg == ST_IDLE) && core_status.ready;
    assign in_take       = message_valid && message_ready;
    assign digest_valid  = (state_reg == ST_OUT);
    assign out_take      = digest_valid && digest_ready;

    // clamp the byte count of the final word
    assign nbytes = (message.valid_bytes > 3'd4) ? 3'd4 : message.valid_bytes;

    // byte mask and pad marker position for a partial final word
    always_comb
    begin
        case (nbytes)
            3'd0:
            begin
                keep_mask = 32'h00000000;
                pad_bits  = {sha1md_pkg::PAD_BYTE, 24'h000000};
            end
            3'd1:
            begin
                keep_mask = 32'hff000000;
                pad_bits  = {8'h00, sha1md_pkg::PAD_BYTE, 16'h0000};
            end
            3'd2:
            begin
                keep_mask = 32'hffff0000;
                pad_bits  = {16'h0000, sha1md_pkg::PAD_BYTE, 8'h00};
            end
            3'd3:
            begin
                keep_mask = 32'hffffff00;
                pad_bits  = {24'h000000, sha1md_pkg::PAD_BYTE};
            end
            default:
            begin
                keep_mask = 32'hffffffff;
                pad_bits  = 32'h00000000;
            end
        endcase
    end

    // padding sequencer and digest read-out
    always_comb
    begin
        state_next     = state_reg;
        index_next     = index_reg;
        bitlen_next    = bitlen_reg;
        core_ctrl.push = 1'b0;
        core_ctrl.init = 1'b0;
        push_word      = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    core_ctrl.push = 1'b1;
                    if (!message.final_word)
                    begin
                        push_word   = message.message_word;
                        bitlen_next = bitlen_reg + 64'd32;
                    end
                    else
                    begin
                        bitlen_next = bitlen_reg + {58'd0, nbytes, 3'b000};
                        if (nbytes == 3'd4)
                        begin
                            push_word  = message.message_word;
                            state_next = ST_PAD;
                        end
                        else
                        begin
                            push_word  = (message.message_word & keep_mask) | pad_bits;
                            state_next = ST_ZERO;
                        end
                    end
                end
            end
            ST_PAD:
            begin
                if (core_status.ready)
                begin
                    core_ctrl.push = 1'b1;
                    push_word      = sha1md_pkg::PAD_WORD;
                    state_next     = ST_ZERO;
                end
            end
            ST_ZERO:
            begin
                if (core_status.ready)
                begin
                    core_ctrl.push = 1'b1;
                    if (core_status.word_count == LEN_HI_SLOT)
                    begin
                        push_word  = bitlen_reg[63:32];
                        state_next = ST_LEN_LO;
                    end
                end
            end
            ST_LEN_LO:
            begin
                if (core_status.ready)
                begin
                    core_ctrl.push = 1'b1;
                    push_word      = bitlen_reg[31:0];
                    state_next     = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (core_status.ready)
                begin
                    index_next = '0;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_take)
                begin
                    if (index_reg == LAST_INDEX)
                    begin
                        core_ctrl.init = 1'b1;
                        bitlen_next    = '0;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        index_next = index_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            index_reg  <= '0;
            bitlen_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            index_reg  <= index_next;
            bitlen_reg <= bitlen_next;
        end
    end

    // digest word select
    always_comb
    begin
        case (index_reg)
            3'd0:    out_word = chain.a;
            3'd1:    out_word = chain.b;
            3'd2:    out_word = chain.c;
            3'd3:    out_word = chain.d;
            default: out_word = chain.e;
        endcase
    end

    assign digest.digest_word  = out_word;
    assign digest.digest_index = index_reg;
    assign digest.digest_done  = (index_reg == LAST_INDEX);

endmodule

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Streams SHA-1 messages into sha1_message_digest and checks every digest
// word against a behavioral hash computed in the testbench, with random
// gaps on the input side and random stalls on the output side.
// ============================================================================

module testbench;

    // one queued message word, with an option to wait for all digests first
    typedef struct packed {
        sha1md_pkg::sha1md_in_t req;
        logic                   hold;
    } pending_t;

    logic                    clk;
    logic                    rst_n = 1'b0;
    logic                    message_valid = 1'b0;
    logic                    message_ready;
    sha1md_pkg::sha1md_in_t  message = '0;
    logic                    digest_valid;
    logic                    digest_ready = 1'b0;
    sha1md_pkg::sha1md_out_t digest;

    // hash state tracked on the testbench side
    logic [31:0] chain_h [5];
    logic [31:0] sched [16];
    logic [3:0]  word_fill;
    logic [63:0] bit_len;

    pending_t                pending_words [$];
    sha1md_pkg::sha1md_out_t expected_digest [$];
    sha1md_pkg::sha1md_out_t want;

    int fail_count = 0;
    int results_seen = 0;
    int words_sent = 0;
    int messages_queued = 0;
    int items_queued = 0;
    int gap_left = 0;
    int burst_left = 0;
    int holdoff_left = 0;
    bit holdoff_done = 1'b0;
    int phase_left = 0;
    bit calm = 1'b1;

    sha1_message_digest dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .message_valid (message_valid),
        .message_ready (message_ready),
        .message       (message),
        .digest_valid  (digest_valid),
        .digest_ready  (digest_ready),
        .digest        (digest)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // 80-round compression of the buffered block into the chain value
    function automatic void compress_block();
        logic [31:0] a, b, c, d, e, f, k, w, t;
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        e = chain_h[4];
        for (int r = 0; r < 80; r++)
        begin
            if (r >= 16)
            begin
                w = sched[(r - 3) & 15] ^ sched[(r - 8) & 15]
                  ^ sched[(r - 14) & 15] ^ sched[r & 15];
                sched[r & 15] = {w[30:0], w[31]};
            end
            w = sched[r & 15];
            if (r < 20)
            begin
                f = (b & c) | (~b & d);
                k = sha1md_pkg::K0;
            end
            else if (r < 40)
            begin
                f = b ^ c ^ d;
                k = sha1md_pkg::K1;
            end
            else if (r < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = sha1md_pkg::K2;
            end
            else
            begin
                f = b ^ c ^ d;
                k = sha1md_pkg::K3;
            end
            t = {a[26:0], a[31:27]} + f + e + w + k;
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t;
        end
        chain_h[0] = chain_h[0] + a;
        chain_h[1] = chain_h[1] + b;
        chain_h[2] = chain_h[2] + c;
        chain_h[3] = chain_h[3] + d;
        chain_h[4] = chain_h[4] + e;
    endfunction

    // buffer one word, compress when the block is full
    function automatic void absorb_word(input logic [31:0] w);
        sched[word_fill] = w;
        word_fill = word_fill + 4'd1;
        if (word_fill == 4'd0)
            compress_block();
    endfunction

    function automatic void restart_hash();
        chain_h[0] = sha1md_pkg::CHAIN_IV.a;
        chain_h[1] = sha1md_pkg::CHAIN_IV.b;
        chain_h[2] = sha1md_pkg::CHAIN_IV.c;
        chain_h[3] = sha1md_pkg::CHAIN_IV.d;
        chain_h[4] = sha1md_pkg::CHAIN_IV.e;
        word_fill = 4'd0;
        bit_len = 64'd0;
    endfunction

    // update the hash with one accepted request; a final word queues the digest
    function automatic void hash_request(input sha1md_pkg::sha1md_in_t req);
        logic [2:0]              n;
        logic [31:0]             keep;
        logic [63:0]             total;
        sha1md_pkg::sha1md_out_t dw;
        if (!req.final_word)
        begin
            bit_len = bit_len + 64'd32;
            absorb_word(req.message_word);
        end
        else
        begin
            n = (req.valid_bytes > 3'd4) ? 3'd4 : req.valid_bytes;
            bit_len = bit_len + 64'(n) * 64'd8;
            total = bit_len;
            if (n == 3'd4)
            begin
                absorb_word(req.message_word);
                absorb_word(sha1md_pkg::PAD_WORD);
            end
            else
            begin
                // bytes past the valid count are cleared, pad byte follows
                keep = ~(32'hffffffff >> (8 * n));
                absorb_word((req.message_word & keep) | (sha1md_pkg::PAD_WORD >> (8 * n)));
            end
            while (word_fill != 4'd14)
                absorb_word(32'h0);
            absorb_word(total[63:32]);
            absorb_word(total[31:0]);
            for (int i = 0; i < 5; i++)
            begin
                dw.digest_word  = chain_h[i];
                dw.digest_index = 3'(i);
                dw.digest_done  = (i == 4);
                expected_digest.push_back(dw);
            end
            restart_hash();
        end
    endfunction

    function automatic void add_item(input logic [31:0] w, input logic [2:0] nb,
                                     input logic fin, input logic hold);
        pending_t p;
        p.req.message_word = w;
        p.req.valid_bytes  = nb;
        p.req.final_word   = fin;
        p.hold             = hold;
        pending_words.push_back(p);
        items_queued++;
        if (fin)
            messages_queued++;
    endfunction

    // message of random content: nwords full words, then a random final word
    function automatic void add_random_message(input int nwords, input logic hold);
        for (int i = 0; i < nwords; i++)
            add_item($urandom, 3'($urandom_range(0, 7)), 1'b0, hold && i == 0);
        add_item($urandom, 3'($urandom_range(0, 7)), 1'b1, hold && nwords == 0);
    endfunction

    // sender: bursts and gaps, with an optional wait for all digests
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            message_valid <= 1'b0;
            message       <= '0;
            gap_left      <= 0;
            burst_left    <= 0;
        end
        else
        begin
            if (message_valid && message_ready)
            begin
                hash_request(message);
                words_sent++;
            end
            if (!message_valid || message_ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left      <= gap_left - 1;
                    message_valid <= 1'b0;
                end
                else if (pending_words.size() == 0 ||
                         (pending_words[0].hold && expected_digest.size() != 0))
                begin
                    message_valid <= 1'b0;
                end
                else
                begin
                    message       <= pending_words[0].req;
                    message_valid <= 1'b1;
                    pending_words.pop_front();
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 16);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                    begin
                        burst_left <= burst_left - 1;
                    end
                end
            end
        end
    end

    // receiver: calm and choppy phases, plus one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digest_ready <= 1'b0;
        end
        else if (holdoff_left != 0)
        begin
            holdoff_left <= holdoff_left - 1;
            digest_ready <= 1'b0;
        end
        else if (!holdoff_done && results_seen >= 40)
        begin
            holdoff_done <= 1'b1;
            holdoff_left <= 400;
            digest_ready <= 1'b0;
        end
        else
        begin
            if (phase_left == 0)
            begin
                calm       <= ~calm;
                phase_left <= $urandom_range(20, 80);
            end
            else
            begin
                phase_left <= phase_left - 1;
            end
            digest_ready <= calm ? 1'b1 : ($urandom_range(0, 3) != 0);
        end
    end

    // compare each digest word with the oldest expected one
    always @(posedge clk)
    begin
        if (rst_n && digest_valid && digest_ready)
        begin
            if (expected_digest.size() == 0)
            begin
                $error("unexpected digest word %h index %0d",
                       digest.digest_word, digest.digest_index);
                fail_count++;
            end
            else
            begin
                want = expected_digest.pop_front();
                results_seen++;
                if (digest.digest_word !== want.digest_word)
                begin
                    $error("digest_word: expected %h, got %h",
                           want.digest_word, digest.digest_word);
                    fail_count++;
                end
                if (digest.digest_index !== want.digest_index)
                begin
                    $error("digest_index: expected %0d, got %0d",
                           want.digest_index, digest.digest_index);
                    fail_count++;
                end
                if (digest.digest_done !== want.digest_done)
                begin
                    $error("digest_done: expected %0d, got %0d",
                           want.digest_done, digest.digest_done);
                    fail_count++;
                end
            end
        end
    end

    // stimulus, reset and end of run
    initial
    begin
        int nwords;
        int sel;
        restart_hash();

        // empty message, pad starts in the final word
        add_item(32'h00000000, 3'd0, 1'b1, 1'b0);
        // three bytes "abc", low byte cleared
        add_item(32'h616263ff, 3'd3, 1'b1, 1'b0);
        // single full word
        add_item(32'hffffffff, 3'd4, 1'b1, 1'b0);
        // valid count above four, non-final word with count ignored
        add_item(32'h00000000, 3'd7, 1'b0, 1'b0);
        add_item(32'hffffffff, 3'd7, 1'b1, 1'b0);
        add_item(32'hdeadbeef, 3'd1, 1'b1, 1'b0);
        add_item(32'h12345678, 3'd2, 1'b1, 1'b0);
        // 56 bytes, padding spills into an extra block
        for (int i = 0; i < 13; i++)
            add_item($urandom, 3'd4, 1'b0, 1'b0);
        add_item($urandom, 3'd4, 1'b1, 1'b0);

        // random messages, mostly short, many near the block boundary
        while (items_queued < 225)
        begin
            sel = $urandom_range(0, 9);
            if (sel < 6)
                nwords = $urandom_range(0, 12);
            else if (sel < 9)
                nwords = $urandom_range(12, 17);
            else
                nwords = $urandom_range(18, 40);
            add_random_message(nwords, messages_queued == 14);
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_words.size() != 0 || message_valid)
            @(posedge clk);
        while (expected_digest.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        $display("run covered %0d messages in %0d requests, %0d digest words checked",
                 messages_queued, words_sent, results_seen);
        $display("including a 400-cycle output hold-off and a drain before one message");
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // run limit
    initial
    begin
        #2000000;
        $display("timeout with %0d digest words outstanding", expected_digest.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule
